>>> rtl/core/ciq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ciq_pkg
// Types, widths and codes shared by the CAN identifier queue and its cells.
// ----------------------------------------------------------------------------
package ciq_pkg;

  // ring size; the chain holds one entry less than the ring
  localparam int DEPTH   = 16;
  localparam int NCELL   = DEPTH - 1;
  localparam int HDL_W   = 8;
  localparam int ID_W    = 29;
  localparam int CAP_W   = 5;
  localparam int OCC_W   = 4;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int CFG_A_W = 2;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_CAP  = 2'd1;

  // capacity limits
  localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(2);
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH);

  // cell operations
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_SHIFT  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // one queued entry
  typedef struct packed {
    logic             valid;
    logic [HDL_W-1:0] handle;
    logic [ID_W-1:0]  id;
  } entry_t;

  // control broadcast to every cell
  typedef struct packed {
    logic [1:0]       op;
    logic             prio;
    logic [HDL_W-1:0] handle;
    logic [ID_W-1:0]  id;
  } cell_ctl_t;

endpackage : ciq_pkg
`default_nettype wire

>>> rtl/core/ciq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ciq_cell
// One slot of the queue chain. Compares its identifier with the incoming one,
// takes its left neighbor on an insert above it, its right neighbor on a pop.
// ----------------------------------------------------------------------------
module ciq_cell
  import ciq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_ctl_t ctl,
  input  wire entry_t    left_entry,
  input  wire logic      left_gt,
  input  wire entry_t    right_entry,
  output entry_t         entry,
  output logic           gt,
  output logic           dup
);

  logic             valid_r;
  logic [HDL_W-1:0] handle_r;
  logic [ID_W-1:0]  id_r;
  entry_t           cur;
  entry_t           entry_nxt;

  // current slot contents
  assign cur = '{valid: valid_r, handle: handle_r, id: id_r};

  // slot is at or past the insert point: empty, or in priority mode holds a larger id
  assign gt  = !cur.valid || (ctl.prio && (cur.id > ctl.id));
  assign dup = ctl.prio && cur.valid && (cur.id == ctl.id);
  assign entry = cur;

  // next slot contents
  always_comb begin
    entry_nxt = cur;
    unique case (ctl.op)
      OP_INSERT: begin
        if (left_gt) begin
          entry_nxt = left_entry;
        end else if (gt) begin
          entry_nxt.valid  = 1'b1;
          entry_nxt.handle = ctl.handle;
          entry_nxt.id     = ctl.id;
        end
      end
      OP_SHIFT: entry_nxt = right_entry;
      OP_CLEAR: entry_nxt.valid = 1'b0;
      default:  entry_nxt = cur;
    endcase
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= entry_nxt.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    handle_r <= entry_nxt.handle;
    id_r     <= entry_nxt.id;
  end

endmodule : ciq_cell
`default_nettype wire

>>> rtl/core/can_id_priority_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// can_id_priority_queue_unit
// Transmit queue of message handles tagged with CAN identifiers, kept as a
// chain of slots: FIFO order or ascending identifier order with duplicates
// dropped. Slot 0 is the front of the queue.
// ----------------------------------------------------------------------------
// The result strobe is registered: it comes in the cycle after the command is accepted.
// Throughput: one command per cycle; every slot compares in parallel and the
// whole chain shifts in the same cycle, so busy stays low.
// Reset: synchronous, active low; queue empty, FIFO mode, capacity 16.
// The result is shown for one cycle only; the receiver cannot stall it.
module can_id_priority_queue_unit
  import ciq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [KIND_W-1:0]  in_kind,
  input  wire logic [HDL_W-1:0]   in_item_handle,
  input  wire logic [ID_W-1:0]    in_can_id,
  // result channel
  output logic                    out_strobe,
  output logic [STAT_W-1:0]       out_status,
  output logic                    out_duplicate_dropped,
  output logic [HDL_W-1:0]        out_handle,
  output logic [ID_W-1:0]         out_can_id,
  output logic [OCC_W-1:0]        out_occupancy,
  // configuration channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CFG_A_W-1:0] cfg_index,
  input  wire logic [CAP_W-1:0]   cfg_data
);

  logic             mode_r, mode_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [OCC_W-1:0] count_r, count_nxt;

  logic              strobe_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              dup_r, dup_nxt;
  logic [HDL_W-1:0]  hdl_r, hdl_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [OCC_W-1:0]  occ_r;

  cell_ctl_t        ctl;
  entry_t           cell_q [NCELL];
  logic [NCELL-1:0] gt_vec;
  logic [NCELL-1:0] dup_vec;

  logic accept;
  logic cfg_wr;
  logic full;
  logic any_dup;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign any_dup   = |dup_vec;
  assign full      = ({1'b0, count_r} == CAP_W'(cap_r - CAP_W'(1)));

  // configuration registers, capacity clamped to the ring limits
  always_comb begin
    mode_nxt = mode_r;
    cap_nxt  = cap_r;
    if (cfg_wr) begin
      if (cfg_index == CFG_MODE) begin
        mode_nxt = cfg_data[0];
      end else if (cfg_index == CFG_CAP) begin
        if (cfg_data < CAP_MIN) begin
          cap_nxt = CAP_MIN;
        end else if (cfg_data > CAP_MAX) begin
          cap_nxt = CAP_MAX;
        end else begin
          cap_nxt = cfg_data;
        end
      end
    end
  end

  // command decode: chain operation, count and result
  always_comb begin
    ctl.op     = OP_HOLD;
    ctl.prio   = mode_r;
    ctl.handle = in_item_handle;
    ctl.id     = in_can_id;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    dup_nxt    = 1'b0;
    hdl_nxt    = '0;
    id_nxt     = '0;
    if (cfg_wr && (cfg_index == CFG_MODE || cfg_index == CFG_CAP)) begin
      ctl.op    = OP_CLEAR;
      count_nxt = '0;
    end else if (accept) begin
      unique case (in_kind)
        KIND_ADD: begin
          if (any_dup) begin
            dup_nxt = 1'b1;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.op    = OP_INSERT;
            count_nxt = OCC_W'(count_r + OCC_W'(1));
          end
        end
        KIND_READ: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctl.op    = OP_SHIFT;
            count_nxt = OCC_W'(count_r - OCC_W'(1));
            hdl_nxt   = cell_q[0].handle;
            id_nxt    = cell_q[0].id;
          end
        end
        KIND_CLEAR: begin
          ctl.op    = OP_CLEAR;
          count_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // chain of slots
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_g;
    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
      assign left_g = gt_vec[i-1];
    end
    if (i == NCELL - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end
    ciq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_entry  (left_e),
      .left_gt     (left_g),
      .right_entry (right_e),
      .entry       (cell_q[i]),
      .gt          (gt_vec[i]),
      .dup         (dup_vec[i])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      cap_r    <= CAP_MAX;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      cap_r    <= cap_nxt;
      count_r  <= count_nxt;
      strobe_r <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    dup_r    <= dup_nxt;
    hdl_r    <= hdl_nxt;
    id_r     <= id_nxt;
    occ_r    <= count_nxt;
  end

  assign out_strobe            = strobe_r;
  assign out_status            = status_r;
  assign out_duplicate_dropped = dup_r;
  assign out_handle            = hdl_r;
  assign out_can_id            = id_r;
  assign out_occupancy         = occ_r;

endmodule : can_id_priority_queue_unit
`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Exercises the CAN identifier transmit queue through its command and
// register ports. A short table of hand-picked commands comes first, then
// randomized fill and drain bursts under several queue modes and ring sizes.
// Every result is compared field by field with a table value or an in-bench model of the ring.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ciq_pkg::*;

  // cycles allowed after the last result before the block counts as idle
  localparam int DRAIN_TAIL  = 4;
  localparam int DRAIN_LIMIT = 100;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 250;

  // register indexes with no register behind them
  localparam logic [CFG_A_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_A_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam int CAP_PICKS [13] = '{0, 1, 2, 3, 4, 5, 7, 8, 11, 15, 16, 17, 31};

  // one result as the block reports it
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              dup;
    logic [HDL_W-1:0]  hdl;
    logic [ID_W-1:0]   id;
    logic [OCC_W-1:0]  occ;
  } qres_t;

  // one directed step: a command, or a register write when is_cfg is set
  typedef struct packed {
    bit                is_cfg;
    logic [KIND_W-1:0] code;
    logic [HDL_W-1:0]  hdl;
    logic [ID_W-1:0]   val;
    bit                typed;
    qres_t             want;
  } cmd_row_t;

  localparam qres_t NO_RES = '0;
  localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

  localparam cmd_row_t DIR_ROWS [30] = '{
    // fifo mode, ring of 16 after reset
    '{1'b0, KIND_READ,  8'h00, 29'h0,        1'b1, '{ST_EMPTY, 1'b0, 8'h00, 29'h0, 4'd0}},
    '{1'b0, KIND_NONE,  8'hFF, ID_MAX,       1'b1, '{ST_OK, 1'b0, 8'h00, 29'h0, 4'd0}},
    '{1'b0, KIND_ADD,   8'hFF, ID_MAX,       1'b1, '{ST_OK, 1'b0, 8'h00, 29'h0, 4'd1}},
    '{1'b0, KIND_ADD,   8'h00, 29'h0,        1'b1, '{ST_OK, 1'b0, 8'h00, 29'h0, 4'd2}},
    '{1'b0, KIND_READ,  8'h00, 29'h0,        1'b1, '{ST_OK, 1'b0, 8'hFF, ID_MAX, 4'd1}},
    '{1'b0, KIND_READ,  8'h00, 29'h0,        1'b1, '{ST_OK, 1'b0, 8'h00, 29'h0, 4'd0}},
    '{1'b0, KIND_ADD,   8'hA5, 29'h15555555, 1'b0, NO_RES},
    '{1'b0, KIND_ADD,   8'h5A, 29'h0AAAAAAA, 1'b0, NO_RES},
    '{1'b0, KIND_READ,  8'h00, 29'h0,        1'b0, NO_RES},
    '{1'b0, KIND_CLEAR, 8'h00, 29'h0,        1'b1, '{ST_OK, 1'b0, 8'h00, 29'h0, 4'd0}},
    '{1'b0, KIND_READ,  8'h00, 29'h0,        1'b1, '{ST_EMPTY, 1'b0, 8'h00, 29'h0, 4'd0}},
    // priority mode, ring size below the minimum so one entry fits
    '{1'b1, CFG_MODE,   8'h00, 29'h01,       1'b0, NO_RES},
    '{1'b1, CFG_CAP,    8'h00, 29'h00,       1'b0, NO_RES},
    '{1'b0, KIND_ADD,   8'h12, 29'd100,      1'b1, '{ST_OK, 1'b0, 8'h00, 29'h0, 4'd1}},
    '{1'b0, KIND_ADD,   8'h34, 29'd100,      1'b1, '{ST_OK, 1'b1, 8'h00, 29'h0, 4'd1}},
    '{1'b0, KIND_ADD,   8'h56, 29'd50,       1'b1, '{ST_FULL, 1'b0, 8'h00, 29'h0, 4'd1}},
    '{1'b0, KIND_READ,  8'h00, 29'h0,        1'b1, '{ST_OK, 1'b0, 8'h12, 29'd100, 4'd0}},
    // ring size above the maximum, sorted insertion with a duplicate
    '{1'b1, CFG_CAP,    8'h00, 29'h1F,       1'b0, NO_RES},
    '{1'b0, KIND_ADD,   8'h01, 29'd300,      1'b0, NO_RES},
    '{1'b0, KIND_ADD,   8'h02, 29'd100,      1'b0, NO_RES},
    '{1'b0, KIND_ADD,   8'h03, 29'd200,      1'b0, NO_RES},
    '{1'b0, KIND_ADD,   8'h04, 29'd100,      1'b0, NO_RES},
    '{1'b0, KIND_ADD,   8'h05, 29'd0,        1'b0, NO_RES},
    // write to an unused index keeps the queue
    '{1'b1, CFG_SPARE_HI, 8'h00, 29'h1F,     1'b0, NO_RES},
    '{1'b0, KIND_READ,  8'h00, 29'h0,        1'b0, NO_RES},
    '{1'b0, KIND_READ,  8'h00, 29'h0,        1'b0, NO_RES},
    '{1'b0, KIND_READ,  8'h00, 29'h0,        1'b0, NO_RES},
    '{1'b0, KIND_READ,  8'h00, 29'h0,        1'b0, NO_RES},
    '{1'b0, KIND_READ,  8'h00, 29'h0,        1'b0, NO_RES},
    '{1'b1, CFG_MODE,   8'h00, 29'h1E,       1'b0, NO_RES}
  };

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [KIND_W-1:0]  in_kind;
  logic [HDL_W-1:0]   in_item_handle;
  logic [ID_W-1:0]    in_can_id;
  logic               out_strobe;
  logic [STAT_W-1:0]  out_status;
  logic               out_duplicate_dropped;
  logic [HDL_W-1:0]   out_handle;
  logic [ID_W-1:0]    out_can_id;
  logic [OCC_W-1:0]   out_occupancy;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_A_W-1:0] cfg_index;
  logic [CAP_W-1:0]   cfg_data;

  can_id_priority_queue_unit u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_kind               (in_kind),
    .in_item_handle        (in_item_handle),
    .in_can_id             (in_can_id),
    .out_strobe            (out_strobe),
    .out_status            (out_status),
    .out_duplicate_dropped (out_duplicate_dropped),
    .out_handle            (out_handle),
    .out_can_id            (out_can_id),
    .out_occupancy         (out_occupancy),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  // ring model state
  bit               prio_mode = 1'b0;
  int               ring_size = DEPTH;
  logic [HDL_W-1:0] slot_hdl [DEPTH];
  logic [ID_W-1:0]  slot_id  [DEPTH];
  int               wr_ptr = 0;
  int               rd_ptr = 0;

  qres_t results_due [$];

  int err_cnt   = 0;
  int n_items   = 0;
  int n_results = 0;
  int n_writes  = 0;
  int n_full    = 0;
  int n_empty   = 0;
  int n_dup     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic int slot_after(input int i);
    return (i + 1 >= ring_size) ? 0 : i + 1;
  endfunction

  function automatic int slot_before(input int i);
    return (i == 0 || i > ring_size) ? ring_size - 1 : i - 1;
  endfunction

  // register write as the ring sees it; real registers also empty the queue
  function automatic void apply_reg(input logic [CFG_A_W-1:0] idx,
                                    input logic [CAP_W-1:0] d);
    if (idx == CFG_MODE) begin
      prio_mode = d[0];
    end else if (idx == CFG_CAP) begin
      ring_size = (d < CAP_MIN) ? int'(CAP_MIN) : (d > CAP_MAX) ? int'(CAP_MAX) : int'(d);
    end else begin
      return;
    end
    wr_ptr = 0;
    rd_ptr = 0;
  endfunction

  // expected result of one command, advancing the ring model
  function automatic qres_t queue_outcome(input logic [KIND_W-1:0] k,
                                          input logic [HDL_W-1:0] h,
                                          input logic [ID_W-1:0] id);
    qres_t r = '0;
    int    pos;
    int    p;
    int    n;
    int    steps;
    bit    hit = 1'b0;
    case (k)
      KIND_ADD: begin
        pos = wr_ptr;
        // sorted mode: find first slot not below the new id
        if (prio_mode) begin
          p = rd_ptr;
          steps = 0;
          while (p != wr_ptr && steps < DEPTH) begin
            if (slot_id[p] == id) begin
              hit = 1'b1;
              break;
            end
            if (slot_id[p] > id) break;
            p = slot_after(p);
            steps++;
          end
          pos = p;
        end
        if (hit) begin
          r.dup = 1'b1;
          n_dup++;
        end else if (slot_after(wr_ptr) == rd_ptr) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          // open a hole at pos by moving the tail end up one slot
          n = wr_ptr;
          steps = 0;
          while (n != pos && steps < DEPTH) begin
            p = slot_before(n);
            slot_hdl[n] = slot_hdl[p];
            slot_id[n] = slot_id[p];
            n = p;
            steps++;
          end
          slot_hdl[pos] = h;
          slot_id[pos] = id;
          wr_ptr = slot_after(wr_ptr);
        end
      end
      KIND_READ: begin
        if (wr_ptr == rd_ptr) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          r.hdl = slot_hdl[rd_ptr];
          r.id = slot_id[rd_ptr];
          rd_ptr = slot_after(rd_ptr);
        end
      end
      KIND_CLEAR: begin
        wr_ptr = 0;
        rd_ptr = 0;
      end
      default: begin
      end
    endcase
    r.occ = OCC_W'((wr_ptr + ring_size - rd_ptr) % ring_size);
    return r;
  endfunction

  // drive one command and hold it until the block takes it; start stays high
  task automatic issue_cmd(input logic [KIND_W-1:0] k, input logic [HDL_W-1:0] h,
                           input logic [ID_W-1:0] id, input bit typed,
                           input qres_t want);
    qres_t r;
    start <= 1'b1;
    in_kind <= k;
    in_item_handle <= h;
    in_can_id <= id;
    do @(posedge clk); while (busy !== 1'b0);
    r = queue_outcome(k, h, id);
    results_due.push_back(typed ? want : r);
    n_items++;
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop sending and wait for every pending result, with a bound
  task automatic drain_results();
    int waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (results_due.size() != 0) begin
      report($sformatf("%0d results never arrived", results_due.size()));
      results_due.delete();
    end
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CAP_W-1:0] d);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    apply_reg(idx, d);
    n_writes++;
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // small id pool so duplicates and ties show up often
  function automatic logic [ID_W-1:0] pick_id();
    int r = $urandom_range(0, 9);
    if (r < 5) return ID_W'($urandom_range(0, 12));
    if (r < 8) return ID_W'($urandom);
    if (r == 8) return ID_MAX - ID_W'($urandom_range(0, 3));
    return ID_W'($urandom_range(0, 12)) << $urandom_range(1, 16);
  endfunction

  // result checker
  always @(posedge clk) begin : chk_results
    qres_t e;
    if (rst_n === 1'b1 && out_strobe !== 1'b0) begin
      if (results_due.size() == 0) begin
        report("result strobe with no command waiting");
      end else begin
        e = results_due.pop_front();
        if (out_status !== e.status)
          report($sformatf("result %0d status 0x%0h, want 0x%0h", n_results,
                           out_status, e.status));
        if (out_duplicate_dropped !== e.dup)
          report($sformatf("result %0d duplicate flag %b, want %b", n_results,
                           out_duplicate_dropped, e.dup));
        if (out_handle !== e.hdl)
          report($sformatf("result %0d handle 0x%0h, want 0x%0h", n_results,
                           out_handle, e.hdl));
        if (out_can_id !== e.id)
          report($sformatf("result %0d id 0x%0h, want 0x%0h", n_results,
                           out_can_id, e.id));
        if (out_occupancy !== e.occ)
          report($sformatf("result %0d occupancy %0d, want %0d", n_results,
                           out_occupancy, e.occ));
      end
      n_results++;
    end
  end

  // stimulus
  initial begin : stim
    cmd_row_t         row;
    int               r;
    int               burst_left;
    bit               filling;
    bit               quiet;
    bit               mode_sel;
    int               cap_sel;
    logic [KIND_W-1:0] k;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_kind <= KIND_NONE;
    in_item_handle <= '0;
    in_can_id <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MODE;
    cfg_data <= '0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_hdl[i] = '0;
      slot_id[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < $size(DIR_ROWS); i++) begin
      row = DIR_ROWS[i];
      if (row.is_cfg) begin
        write_reg(row.code, row.val[CAP_W-1:0]);
      end else begin
        issue_cmd(row.code, row.hdl, row.val, row.typed, row.want);
        pause(pick_gap());
      end
    end

    // random phases, each under its own mode and ring size
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        mode_sel = 1'b1;
        cap_sel = 16;
      end else if (ph == 1) begin
        mode_sel = 1'b0;
        cap_sel = 1;
      end else if (ph == 2) begin
        mode_sel = 1'b1;
        cap_sel = 2;
      end else begin
        mode_sel = 1'($urandom_range(0, 1));
        cap_sel = CAP_PICKS[$urandom_range(0, 12)];
      end
      if ($urandom_range(0, 1) == 1) begin
        write_reg(CFG_MODE, {(CAP_W-1)'($urandom), mode_sel});
        write_reg(CFG_CAP, CAP_W'(cap_sel));
      end else begin
        write_reg(CFG_CAP, CAP_W'(cap_sel));
        write_reg(CFG_MODE, {(CAP_W-1)'($urandom), mode_sel});
      end
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, CAP_W'($urandom));

      quiet = ($urandom_range(0, 3) == 0);
      filling = 1'b1;
      burst_left = $urandom_range(5, 30);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // alternate fill-heavy and drain-heavy bursts
        if (burst_left == 0) begin
          filling = !filling;
          burst_left = $urandom_range(5, 30);
        end
        burst_left--;
        r = $urandom_range(0, 99);
        if (r < 4) k = KIND_CLEAR;
        else if (r < 7) k = KIND_NONE;
        else if (r < (filling ? 75 : 30)) k = KIND_ADD;
        else k = KIND_READ;
        issue_cmd(k, HDL_W'($urandom), pick_id(), 1'b0, NO_RES);
        if (i == PHASE_ITEMS / 2) drain_results();
        else pause(quiet ? 0 : pick_gap());
      end
    end

    drain_results();
    $display("run covered %0d commands and %0d register writes", n_items, n_writes);
    $display("  %0d full refusals, %0d empty reads, %0d duplicates dropped, %0d errors",
             n_full, n_empty, n_dup, err_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule : tb
